/* rtl/core/hhfe_pkg.sv */
// Shared types, constants and character helpers for the HTTP header field extractor.
// Used by every module of the block; depends on nothing else.

package hhfe_pkg;

   localparam int KW_BITS = 128;
   localparam int MAX_CAPTURE_DEFAULT = 15;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [KW_BITS-1:0] KW_SERVER = KW_BITS'("Server");
   localparam logic [KW_BITS-1:0] KW_TYPE = KW_BITS'("Content-Type");
   localparam logic [KW_BITS-1:0] KW_LENGTH = KW_BITS'("Content-Length");
   localparam int KW_SERVER_LEN = 6;
   localparam int KW_TYPE_LEN = 12;
   localparam int KW_LENGTH_LEN = 14;

   localparam logic [3:0] CODE_OFFSET = 4'd9;
   localparam logic [13:0] CODE_SAT = 14'd9999;
   localparam logic [13:0] CODE_OK = 14'd200;
   localparam logic [30:0] LEN_SAT = 31'h7FFF_FFFF;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS = 8'h2B;

   localparam logic [1:0] KIND_SERVER = 2'd0;
   localparam logic [1:0] KIND_TYPE = 2'd1;
   localparam logic [1:0] KIND_SUMMARY = 2'd2;

   typedef enum logic [3:0] {
      PH_SEARCH = 4'b0001,
      PH_SKIP   = 4'b0010,
      PH_TAKE   = 4'b0100,
      PH_DONE   = 4'b1000
   } phase_type;

   typedef enum logic [3:0] {
      CP_WAIT   = 4'b0001,
      CP_LEAD   = 4'b0010,
      CP_DIGITS = 4'b0100,
      CP_DONE   = 4'b1000
   } code_phase_type;

   // One queue entry holds every result that a single request causes.
   typedef struct packed {
      logic               has_server;
      logic               has_type;
      logic               has_summary;
      logic [7:0]         value_char;
      logic signed [14:0] status_code;
      logic               success;
      logic [30:0]        content_length;
   } entry_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   // The keywords have no border, so a mismatch restarts at zero or one.
   function automatic logic [3:0] match_next(input logic [KW_BITS-1:0] kw,
                                             input logic [3:0] len,
                                             input logic [3:0] m,
                                             input logic [7:0] c);
      logic [3:0] idx;
      logic [3:0] first_idx;
      logic [7:0] want;
      logic [7:0] first;
      logic [3:0] res;
      idx = len - m - 4'd1;
      first_idx = len - 4'd1;
      want = kw[{idx, 3'b000} +: 8];
      first = kw[{first_idx, 3'b000} +: 8];
      if (m < len && c == want) begin
         res = m + 4'd1;
      end else if (c == first) begin
         res = 4'd1;
      end else begin
         res = 4'd0;
      end
      return res;
   endfunction

endpackage

/* rtl/core/http_header_field_extractor.sv */
// HTTP response header field extractor, top level. Accepts one request byte per cycle
// while the queue is not full. Results pass through the queue, the back end's entry register
// and the response register, and leave one per cycle while rsp_ready is high. A byte with
// several results holds the back end until all have left, while later bytes queue behind it.
// Synchronous active-high reset returns all parsers to their initial state and empties the queue.
// Depends on hhfe_pkg, hhfe_front, hhfe_queue and hhfe_back.

module http_header_field_extractor #(
   parameter int MAX_CAPTURE = hhfe_pkg::MAX_CAPTURE_DEFAULT,
   parameter int QUEUE_DEPTH = hhfe_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_text_byte,
   input  logic               req_end_of_text,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_kind,
   output logic [7:0]         rsp_value_char,
   output logic signed [14:0] rsp_status_code,
   output logic               rsp_success,
   output logic [30:0]        rsp_content_length,
   output logic               rsp_last_of_run
);

   logic                q_full;
   logic                q_push;
   logic                q_pop;
   logic                q_nonempty;
   hhfe_pkg::entry_type q_push_data;
   hhfe_pkg::entry_type q_head;

   hhfe_front #(
      .MAX_CAPTURE(MAX_CAPTURE)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_text_byte(req_text_byte),
      .req_end_of_text(req_end_of_text),
      .q_full(q_full),
      .push(q_push),
      .push_data(q_push_data)
   );

   hhfe_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_data(q_push_data),
      .pop(q_pop),
      .full(q_full),
      .nonempty(q_nonempty),
      .head(q_head)
   );

   hhfe_back u_back (
      .clock(clock),
      .reset(reset),
      .q_nonempty(q_nonempty),
      .q_head(q_head),
      .q_pop(q_pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_value_char(rsp_value_char),
      .rsp_status_code(rsp_status_code),
      .rsp_success(rsp_success),
      .rsp_content_length(rsp_content_length),
      .rsp_last_of_run(rsp_last_of_run)
   );

   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == hhfe_pkg::KIND_SUMMARY |-> rsp_last_of_run)
      else $error("summary result is not the last of its run");

   a_value_fields_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != hhfe_pkg::KIND_SUMMARY
      |-> rsp_status_code == 15'sd0 && !rsp_success && rsp_content_length == 31'd0)
      else $error("value result carries summary fields");

   a_success_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_success |-> rsp_status_code == 15'sd200)
      else $error("success flagged without status 200");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_full && !q_pop |=> !(q_push && $past(q_full)) || q_pop || !q_full)
      else $error("queue written while full");

endmodule

/* rtl/core/hhfe_capture.sv */
// Keyword matcher and bounded value capture for one text header field.
// Depends on hhfe_pkg for the phase type and character helpers.

module hhfe_capture #(
   parameter logic [hhfe_pkg::KW_BITS-1:0] KEYWORD = hhfe_pkg::KW_SERVER,
   parameter int KW_LEN = hhfe_pkg::KW_SERVER_LEN,
   parameter int MAX_CAPTURE = hhfe_pkg::MAX_CAPTURE_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] byte_in,
   input  logic       step,
   input  logic       restart,
   output logic       emit
);

   localparam int CNT_W = $clog2(MAX_CAPTURE + 1);

   hhfe_pkg::phase_type phase_ff, phase_in;
   logic [3:0]          match_ff, match_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [3:0]          match_new;

   always_comb begin
      phase_in = phase_ff;
      match_in = match_ff;
      count_in = count_ff;
      emit = 1'b0;
      match_new = hhfe_pkg::match_next(KEYWORD, 4'(KW_LEN), match_ff, byte_in);
      unique case (phase_ff)
         hhfe_pkg::PH_SEARCH: begin
            match_in = match_new;
            if (match_new == 4'(KW_LEN)) begin
               phase_in = hhfe_pkg::PH_SKIP;
            end
         end
         hhfe_pkg::PH_SKIP, hhfe_pkg::PH_TAKE: begin
            if (phase_ff == hhfe_pkg::PH_TAKE || hhfe_pkg::is_letter(byte_in)) begin
               if (byte_in == hhfe_pkg::CHAR_NEWLINE
                   || count_ff >= CNT_W'(MAX_CAPTURE)) begin
                  phase_in = hhfe_pkg::PH_DONE;
               end else begin
                  count_in = count_ff + CNT_W'(1);
                  emit = 1'b1;
                  if (count_ff == CNT_W'(MAX_CAPTURE - 1)) begin
                     phase_in = hhfe_pkg::PH_DONE;
                  end else begin
                     phase_in = hhfe_pkg::PH_TAKE;
                  end
               end
            end
         end
         hhfe_pkg::PH_DONE: begin
         end
         default: begin
            phase_in = hhfe_pkg::PH_SEARCH;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hhfe_pkg::PH_SEARCH;
         match_ff <= 4'd0;
         count_ff <= '0;
      end else if (step) begin
         if (restart) begin
            phase_ff <= hhfe_pkg::PH_SEARCH;
            match_ff <= 4'd0;
            count_ff <= '0;
         end else begin
            phase_ff <= phase_in;
            match_ff <= match_in;
            count_ff <= count_in;
         end
      end
   end

endmodule

/* rtl/core/hhfe_front.sv */
// Front end: accepts request bytes, parses status code and Content-Length,
// runs the two text captures and pushes one entry per request with results.
// Depends on hhfe_pkg and hhfe_capture.

module hhfe_front #(
   parameter int MAX_CAPTURE = hhfe_pkg::MAX_CAPTURE_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_text_byte,
   input  logic                req_end_of_text,
   input  logic                q_full,
   output logic                push,
   output hhfe_pkg::entry_type push_data
);

   logic accept;
   logic server_emit;
   logic type_emit;

   logic [3:0]               pos_ff, pos_in;
   hhfe_pkg::code_phase_type code_ph_ff, code_ph_in;
   logic [13:0]              code_val_ff, code_val_in;
   logic                     code_neg_ff, code_neg_in;
   logic [17:0]              code_acc;

   hhfe_pkg::phase_type len_ph_ff, len_ph_in;
   logic [3:0]          len_match_ff, len_match_in;
   logic [30:0]         len_val_ff, len_val_in;
   logic [34:0]         len_acc;
   logic [3:0]          len_match_new;
   logic [3:0]          digit;
   logic [14:0]         code_mag;

   assign req_ready = !q_full;
   assign accept = req_valid && req_ready;
   assign digit = 4'(req_text_byte - 8'h30);

   hhfe_capture #(
      .KEYWORD(hhfe_pkg::KW_SERVER),
      .KW_LEN(hhfe_pkg::KW_SERVER_LEN),
      .MAX_CAPTURE(MAX_CAPTURE)
   ) u_server (
      .clock(clock),
      .reset(reset),
      .byte_in(req_text_byte),
      .step(accept),
      .restart(req_end_of_text),
      .emit(server_emit)
   );

   hhfe_capture #(
      .KEYWORD(hhfe_pkg::KW_TYPE),
      .KW_LEN(hhfe_pkg::KW_TYPE_LEN),
      .MAX_CAPTURE(MAX_CAPTURE)
   ) u_type (
      .clock(clock),
      .reset(reset),
      .byte_in(req_text_byte),
      .step(accept),
      .restart(req_end_of_text),
      .emit(type_emit)
   );

   always_comb begin
      pos_in = pos_ff;
      code_ph_in = code_ph_ff;
      code_val_in = code_val_ff;
      code_neg_in = code_neg_ff;
      code_acc = ({4'd0, code_val_ff} << 3) + ({4'd0, code_val_ff} << 1) + 18'(digit);
      if (code_ph_in == hhfe_pkg::CP_WAIT) begin
         if (pos_ff < hhfe_pkg::CODE_OFFSET) begin
            pos_in = pos_ff + 4'd1;
         end else begin
            code_ph_in = hhfe_pkg::CP_LEAD;
         end
      end
      if (code_ph_in == hhfe_pkg::CP_LEAD && !hhfe_pkg::is_space(req_text_byte)) begin
         if (req_text_byte == hhfe_pkg::CHAR_MINUS || req_text_byte == hhfe_pkg::CHAR_PLUS) begin
            code_ph_in = hhfe_pkg::CP_DIGITS;
            code_neg_in = (req_text_byte == hhfe_pkg::CHAR_MINUS);
         end else begin
            code_ph_in = hhfe_pkg::CP_DIGITS;
            if (hhfe_pkg::is_digit(req_text_byte)) begin
               code_val_in = (code_acc > 18'(hhfe_pkg::CODE_SAT))
                             ? hhfe_pkg::CODE_SAT : code_acc[13:0];
            end else begin
               code_ph_in = hhfe_pkg::CP_DONE;
            end
         end
      end else if (code_ph_in == hhfe_pkg::CP_DIGITS && code_ph_ff == hhfe_pkg::CP_DIGITS) begin
         if (hhfe_pkg::is_digit(req_text_byte)) begin
            code_val_in = (code_acc > 18'(hhfe_pkg::CODE_SAT))
                          ? hhfe_pkg::CODE_SAT : code_acc[13:0];
         end else begin
            code_ph_in = hhfe_pkg::CP_DONE;
         end
      end
   end

   always_comb begin
      len_ph_in = len_ph_ff;
      len_match_in = len_match_ff;
      len_val_in = len_val_ff;
      len_match_new = hhfe_pkg::match_next(hhfe_pkg::KW_LENGTH, 4'(hhfe_pkg::KW_LENGTH_LEN),
                                           len_match_ff, req_text_byte);
      len_acc = ({4'd0, len_val_ff} << 3) + ({4'd0, len_val_ff} << 1) + 35'(digit);
      unique case (len_ph_ff)
         hhfe_pkg::PH_SEARCH: begin
            len_match_in = len_match_new;
            if (len_match_new == 4'(hhfe_pkg::KW_LENGTH_LEN)) begin
               len_ph_in = hhfe_pkg::PH_SKIP;
            end
         end
         hhfe_pkg::PH_SKIP, hhfe_pkg::PH_TAKE: begin
            if (hhfe_pkg::is_digit(req_text_byte)) begin
               len_ph_in = hhfe_pkg::PH_TAKE;
               len_val_in = (len_acc > 35'(hhfe_pkg::LEN_SAT))
                            ? hhfe_pkg::LEN_SAT : len_acc[30:0];
            end else if (len_ph_ff == hhfe_pkg::PH_TAKE) begin
               len_ph_in = hhfe_pkg::PH_DONE;
            end
         end
         hhfe_pkg::PH_DONE: begin
         end
         default: begin
            len_ph_in = hhfe_pkg::PH_SEARCH;
         end
      endcase
   end

   always_comb begin
      code_mag = {1'b0, code_val_in};
      push = accept && (server_emit || type_emit || req_end_of_text);
      push_data.has_server = server_emit;
      push_data.has_type = type_emit;
      push_data.has_summary = req_end_of_text;
      push_data.value_char = req_text_byte;
      push_data.status_code = code_neg_in ? $signed(15'd0 - code_mag) : $signed(code_mag);
      push_data.success = !code_neg_in && (code_val_in == hhfe_pkg::CODE_OK);
      push_data.content_length = len_val_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_end_of_text)) begin
         pos_ff <= 4'd0;
         code_ph_ff <= hhfe_pkg::CP_WAIT;
         code_val_ff <= 14'd0;
         code_neg_ff <= 1'b0;
         len_ph_ff <= hhfe_pkg::PH_SEARCH;
         len_match_ff <= 4'd0;
         len_val_ff <= 31'd0;
      end else if (accept) begin
         pos_ff <= pos_in;
         code_ph_ff <= code_ph_in;
         code_val_ff <= code_val_in;
         code_neg_ff <= code_neg_in;
         len_ph_ff <= len_ph_in;
         len_match_ff <= len_match_in;
         len_val_ff <= len_val_in;
      end
   end

endmodule

/* rtl/core/hhfe_queue.sv */
// Short first-in first-out queue of result entries between front and back end.
// Depends on hhfe_pkg for the entry type.

module hhfe_queue #(
   parameter int DEPTH = hhfe_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  hhfe_pkg::entry_type push_data,
   input  logic                pop,
   output logic                full,
   output logic                nonempty,
   output hhfe_pkg::entry_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   hhfe_pkg::entry_type slots_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign nonempty = (count_ff != '0);
   assign head = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/core/hhfe_back.sv */
// Back end: unpacks each queued entry into its results in order and drives
// the registered response channel. Depends on hhfe_pkg.

module hhfe_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_nonempty,
   input  hhfe_pkg::entry_type q_head,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_kind,
   output logic [7:0]          rsp_value_char,
   output logic signed [14:0]  rsp_status_code,
   output logic                rsp_success,
   output logic [30:0]         rsp_content_length,
   output logic                rsp_last_of_run
);

   hhfe_pkg::entry_type cur_ff;
   logic [2:0]          mask_ff, mask_in;
   logic [2:0]          pick;
   logic [2:0]          rest;
   logic                advance;

   logic               valid_ff, valid_in;
   logic [1:0]         kind_ff, kind_in;
   logic [7:0]         char_ff, char_in;
   logic signed [14:0] code_ff, code_in;
   logic               ok_ff, ok_in;
   logic [30:0]        len_ff, len_in;
   logic               last_ff, last_in;

   assign advance = (!valid_ff || rsp_ready) && (mask_ff != 3'b000);

   always_comb begin
      kind_in = kind_ff;
      char_in = char_ff;
      code_in = code_ff;
      ok_in = ok_ff;
      len_in = len_ff;
      priority if (mask_ff[0]) begin
         pick = 3'b001;
         kind_in = hhfe_pkg::KIND_SERVER;
      end else if (mask_ff[1]) begin
         pick = 3'b010;
         kind_in = hhfe_pkg::KIND_TYPE;
      end else begin
         pick = 3'b100;
         kind_in = hhfe_pkg::KIND_SUMMARY;
      end
      rest = mask_ff & ~pick;
      if (kind_in == hhfe_pkg::KIND_SUMMARY) begin
         char_in = 8'd0;
         code_in = cur_ff.status_code;
         ok_in = cur_ff.success;
         len_in = cur_ff.content_length;
      end else begin
         char_in = cur_ff.value_char;
         code_in = 15'sd0;
         ok_in = 1'b0;
         len_in = 31'd0;
      end
      last_in = (rest == 3'b000);

      if (advance) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end

      q_pop = q_nonempty && ((mask_ff == 3'b000) || (advance && rest == 3'b000));
      if (q_pop) begin
         mask_in = {q_head.has_summary, q_head.has_type, q_head.has_server};
      end else if (advance) begin
         mask_in = rest;
      end else begin
         mask_in = mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= 3'b000;
         valid_ff <= 1'b0;
      end else begin
         mask_ff <= mask_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_head;
      end
      if (advance) begin
         kind_ff <= kind_in;
         char_ff <= char_in;
         code_ff <= code_in;
         ok_ff <= ok_in;
         len_ff <= len_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_kind = kind_ff;
   assign rsp_value_char = char_ff;
   assign rsp_status_code = code_ff;
   assign rsp_success = ok_ff;
   assign rsp_content_length = len_ff;
   assign rsp_last_of_run = last_ff;

endmodule

/* bench/hhfe_tb_pkg.sv */
`timescale 1ns / 1ps
// Scoreboard for the HTTP header field extractor testbench: a byte-level predictor of the
// extracted fields and the queue of responses still awaited. Depends on hhfe_pkg.

package hhfe_tb_pkg;

   localparam int CAPTURE_LIMIT = hhfe_pkg::MAX_CAPTURE_DEFAULT;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic [1:0]         kind;
      logic [7:0]         value_char;
      logic signed [14:0] status_code;
      logic               success;
      logic [30:0]        content_length;
      logic               last_of_run;
   } field_result_type;

   class field_scoreboard;
      field_result_type awaited[$];
      int failures;
      string value_keyword[2];
      string length_keyword;
      int unsigned position;
      hhfe_pkg::code_phase_type code_state;
      int unsigned code_magnitude;
      bit code_negative;
      int unsigned value_hits[2];
      hhfe_pkg::phase_type value_state[2];
      int unsigned value_taken[2];
      int unsigned length_hits;
      hhfe_pkg::phase_type length_state;
      longint unsigned length_total;

      function new();
         value_keyword[0] = "Server";
         value_keyword[1] = "Content-Type";
         length_keyword = "Content-Length";
         failures = 0;
         restart();
      endfunction

      function void restart();
         position = 0;
         code_state = hhfe_pkg::CP_WAIT;
         code_magnitude = 0;
         code_negative = 1'b0;
         length_hits = 0;
         length_state = hhfe_pkg::PH_SEARCH;
         length_total = 0;
         for (int i = 0; i < 2; i++) begin
            value_hits[i] = 0;
            value_state[i] = hhfe_pkg::PH_SEARCH;
            value_taken[i] = 0;
         end
      endfunction

      function bit letter_char(byte unsigned c);
         return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
      endfunction

      function bit digit_char(byte unsigned c);
         return c >= "0" && c <= "9";
      endfunction

      function bit blank_char(byte unsigned c);
         return c == " " || (c >= 8'h09 && c <= 8'h0D);
      endfunction

      function int unsigned advance_match(string kw, int unsigned hits, byte unsigned c);
         byte unsigned want;
         byte unsigned first;
         first = kw[0];
         want = (hits < kw.len()) ? kw[hits] : 8'h00;
         if (hits < kw.len() && c == want) begin
            return hits + 1;
         end
         return (c == first) ? 1 : 0;
      endfunction

      function void step_status_code(byte unsigned c);
         if (code_state == hhfe_pkg::CP_WAIT) begin
            if (position < hhfe_pkg::CODE_OFFSET) begin
               position++;
               return;
            end
            code_state = hhfe_pkg::CP_LEAD;
         end
         if (code_state == hhfe_pkg::CP_LEAD) begin
            if (blank_char(c)) begin
               return;
            end
            code_state = hhfe_pkg::CP_DIGITS;
            if (c == hhfe_pkg::CHAR_MINUS || c == hhfe_pkg::CHAR_PLUS) begin
               code_negative = (c == hhfe_pkg::CHAR_MINUS);
               return;
            end
         end
         if (code_state == hhfe_pkg::CP_DIGITS) begin
            if (digit_char(c)) begin
               code_magnitude = code_magnitude * 10 + (c - 8'h30);
               if (code_magnitude > hhfe_pkg::CODE_SAT) begin
                  code_magnitude = hhfe_pkg::CODE_SAT;
               end
            end else begin
               code_state = hhfe_pkg::CP_DONE;
            end
         end
      endfunction

      // Returns 1 when the byte belongs to the captured value of keyword idx.
      function bit step_capture(int idx, byte unsigned c);
         if (value_state[idx] == hhfe_pkg::PH_SEARCH) begin
            value_hits[idx] = advance_match(value_keyword[idx], value_hits[idx], c);
            if (value_hits[idx] == value_keyword[idx].len()) begin
               value_state[idx] = hhfe_pkg::PH_SKIP;
            end
            return 1'b0;
         end
         if (value_state[idx] == hhfe_pkg::PH_SKIP) begin
            if (!letter_char(c)) begin
               return 1'b0;
            end
            value_state[idx] = hhfe_pkg::PH_TAKE;
         end
         if (value_state[idx] != hhfe_pkg::PH_TAKE) begin
            return 1'b0;
         end
         if (c == hhfe_pkg::CHAR_NEWLINE || value_taken[idx] >= CAPTURE_LIMIT) begin
            value_state[idx] = hhfe_pkg::PH_DONE;
            return 1'b0;
         end
         value_taken[idx]++;
         if (value_taken[idx] >= CAPTURE_LIMIT) begin
            value_state[idx] = hhfe_pkg::PH_DONE;
         end
         return 1'b1;
      endfunction

      function void step_length(byte unsigned c);
         if (length_state == hhfe_pkg::PH_SEARCH) begin
            length_hits = advance_match(length_keyword, length_hits, c);
            if (length_hits == length_keyword.len()) begin
               length_state = hhfe_pkg::PH_SKIP;
            end
            return;
         end
         if (length_state == hhfe_pkg::PH_SKIP) begin
            if (!digit_char(c)) begin
               return;
            end
            length_state = hhfe_pkg::PH_TAKE;
         end
         if (length_state == hhfe_pkg::PH_TAKE) begin
            if (digit_char(c)) begin
               length_total = length_total * 10 + (c - 8'h30);
               if (length_total > hhfe_pkg::LEN_SAT) begin
                  length_total = hhfe_pkg::LEN_SAT;
               end
            end else begin
               length_state = hhfe_pkg::PH_DONE;
            end
         end
      endfunction

      function void note_request(byte unsigned c, bit final_byte);
         field_result_type r;
         field_result_type batch[$];
         step_status_code(c);
         for (int i = 0; i < 2; i++) begin
            if (step_capture(i, c)) begin
               r = '{default: '0};
               r.kind = (i == 0) ? hhfe_pkg::KIND_SERVER : hhfe_pkg::KIND_TYPE;
               r.value_char = c;
               batch.push_back(r);
            end
         end
         step_length(c);
         if (final_byte) begin
            r = '{default: '0};
            r.kind = hhfe_pkg::KIND_SUMMARY;
            r.status_code = 15'(code_magnitude);
            if (code_negative) begin
               r.status_code = -r.status_code;
            end
            r.success = !code_negative && code_magnitude == hhfe_pkg::CODE_OK;
            r.content_length = length_total[30:0];
            batch.push_back(r);
            restart();
         end
         if (batch.size() > 0) begin
            batch[batch.size() - 1].last_of_run = 1'b1;
         end
         foreach (batch[i]) begin
            awaited.push_back(batch[i]);
         end
      endfunction

      function void flag(string msg);
         failures++;
         if (failures <= REPORT_LIMIT) begin
            $display("%0t: %s", $time, msg);
         end
      endfunction

      function void check_response(field_result_type got);
         field_result_type want;
         if (awaited.size() == 0) begin
            flag($sformatf("response of kind %0d arrived with none awaited", got.kind));
            return;
         end
         want = awaited.pop_front();
         if (got.kind !== want.kind) begin
            flag($sformatf("kind: expected %0d, got %0d", want.kind, got.kind));
         end
         if (got.value_char !== want.value_char) begin
            flag($sformatf("value_char: expected %0h, got %0h", want.value_char,
                           got.value_char));
         end
         if (got.status_code !== want.status_code) begin
            flag($sformatf("status_code: expected %0d, got %0d", want.status_code,
                           got.status_code));
         end
         if (got.success !== want.success) begin
            flag($sformatf("success: expected %0d, got %0d", want.success, got.success));
         end
         if (got.content_length !== want.content_length) begin
            flag($sformatf("content_length: expected %0d, got %0d", want.content_length,
                           got.content_length));
         end
         if (got.last_of_run !== want.last_of_run) begin
            flag($sformatf("last_of_run: expected %0d, got %0d", want.last_of_run,
                           got.last_of_run));
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

endpackage

/* bench/http_header_field_extractor_tb.sv */
`timescale 1ns / 1ps
// Top-level testbench for the HTTP header field extractor: sends generated HTTP replies
// byte by byte with random stalls on both sides and checks every response.
// Depends on hhfe_pkg, hhfe_tb_pkg and the RTL of the block.

module http_header_field_extractor_tb;

   localparam int HALF_PERIOD = 5;
   localparam int STALL_LIMIT = 2000;
   localparam int TARGET_BYTES = 300;
   localparam int SETTLE_CYCLES = 20;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_text_byte = 8'h00;
   logic               req_end_of_text = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_kind;
   logic [7:0]         rsp_value_char;
   logic signed [14:0] rsp_status_code;
   logic               rsp_success;
   logic [30:0]        rsp_content_length;
   logic               rsp_last_of_run;

   hhfe_tb_pkg::field_scoreboard sb;
   bit quiet = 1'b0;
   int sent = 0;
   byte unsigned reply_bytes[$];
   byte unsigned blank_bytes[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
   string near_misses[7] = '{"Serve", "SServer", "server", "Content-Typ", "Content-Lengt",
                             "Content-Content-Type", "ContentLength"};

   http_header_field_extractor dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_text_byte      (req_text_byte),
      .req_end_of_text    (req_end_of_text),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_value_char     (rsp_value_char),
      .rsp_status_code    (rsp_status_code),
      .rsp_success        (rsp_success),
      .rsp_content_length (rsp_content_length),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin : port_monitor
      hhfe_tb_pkg::field_result_type got;
      if (!reset && req_valid && req_ready) begin
         sb.note_request(req_text_byte, req_end_of_text);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         got.kind = rsp_kind;
         got.value_char = rsp_value_char;
         got.status_code = rsp_status_code;
         got.success = rsp_success;
         got.content_length = rsp_content_length;
         got.last_of_run = rsp_last_of_run;
         sb.check_response(got);
      end
   end

   function automatic int pick_gap();
      int r;
      if (quiet) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end
      if (r < 85) begin
         return $urandom_range(1, 3);
      end
      if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) begin
         reply_bytes.push_back(s[i]);
      end
   endfunction

   function automatic void push_pick(string set);
      reply_bytes.push_back(set[$urandom_range(0, set.len() - 1)]);
   endfunction

   function automatic void push_noise(int n);
      repeat (n) begin
         reply_bytes.push_back(8'($urandom_range(0, 255)));
      end
   endfunction

   function automatic void push_digits(int n);
      repeat (n) begin
         push_pick("0123456789");
      end
   endfunction

   function automatic void push_value();
      int n;
      case ($urandom_range(0, 3))
         0: push_text(": ");
         1: push_text(":");
         2: push_text(": 1 ");
         default: push_text(":\r\n ");
      endcase
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 20) : $urandom_range(0, 6);
      repeat (n) begin
         if ($urandom_range(0, 4) == 0) begin
            push_noise(1);
         end else begin
            push_pick("abcxyzABCXYZ019/-.; ");
         end
      end
      case ($urandom_range(0, 3))
         0: push_text("\n");
         1: ;
         default: push_text("\r\n");
      endcase
   endfunction

   function automatic void build_reply();
      int cut;
      reply_bytes.delete();
      if ($urandom_range(0, 7) == 0) begin
         push_noise($urandom_range(0, 12));
      end else begin
         push_text($urandom_range(0, 1) ? "HTTP/1.1 " : "HTTP/1.0 ");
      end
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0) begin
         reply_bytes.push_back(blank_bytes[$urandom_range(0, 5)]);
      end
      case ($urandom_range(0, 5))
         0: push_text("-");
         1: push_text("+");
         default: ;
      endcase
      case ($urandom_range(0, 3))
         0, 1: push_text("200");
         2: push_digits($urandom_range(0, 3));
         default: push_digits($urandom_range(4, 7));
      endcase
      push_text($urandom_range(0, 1) ? " OK\r\n" : "\n");
      repeat ($urandom_range(1, 4)) begin
         case ($urandom_range(0, 6))
            0, 1: begin
               push_text("Server");
               push_value();
            end
            2, 3: begin
               push_text("Content-Type");
               push_value();
            end
            4: begin
               push_text("Content-Length");
               push_text($urandom_range(0, 1) ? ": " : ":\n");
               push_digits(($urandom_range(0, 3) == 0) ? $urandom_range(10, 12)
                                                         : $urandom_range(1, 5));
               push_text("\r\n");
            end
            5: push_text(near_misses[$urandom_range(0, 6)]);
            default: push_noise($urandom_range(1, 6));
         endcase
      end
      if ($urandom_range(0, 6) == 0) begin
         cut = $urandom_range(1, reply_bytes.size());
         while (reply_bytes.size() > cut) begin
            void'(reply_bytes.pop_back());
         end
      end
      if (reply_bytes.size() == 0) begin
         push_noise(1);
      end
   endfunction

   task automatic send_reply();
      int gap;
      for (int i = 0; i < reply_bytes.size(); i++) begin
         req_valid <= 1'b1;
         req_text_byte <= reply_bytes[i];
         req_end_of_text <= (i == reply_bytes.size() - 1);
         @(posedge clock);
         while (!req_ready) begin
            @(posedge clock);
         end
         sent++;
         gap = pick_gap();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin : response_sink
      int hold;
      forever begin
         @(posedge clock);
         hold = pick_gap();
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(0, 6)) @(posedge clock);
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle = 0;
         end else begin
            idle++;
         end
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      reply_bytes = '{8'h00, 8'hFF};
      send_reply();
      reply_bytes.delete();
      push_text("HTTP/1.1 -0");
      send_reply();
      reply_bytes.delete();
      push_text("HTTP/1.1 \t+");
      send_reply();
      req_valid <= 1'b0;
      wait_drained();

      while (sent < TARGET_BYTES) begin
         quiet = ($urandom_range(0, 4) == 0);
         build_reply();
         send_reply();
         if ($urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            wait_drained();
         end
      end
      req_valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* http_header_field_extractor.f */
rtl/core/hhfe_pkg.sv
rtl/core/hhfe_capture.sv
rtl/core/hhfe_front.sv
rtl/core/hhfe_queue.sv
rtl/core/hhfe_back.sv
rtl/core/http_header_field_extractor.sv
bench/hhfe_tb_pkg.sv
bench/http_header_field_extractor_tb.sv
